/* rtl/core/fmr_pkg.sv */
// Shared types and constants for the fraction multiply and reduce block.
// Used by fmr_unit and fraction_multiply_reduce; depends on nothing else.
package fmr_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int MAG_W         = PROD_W - 1;
    localparam int RES_W         = 32;
    localparam int WIDE_W        = (PROD_W > RES_W) ? PROD_W : RES_W;
    localparam int CNT_W         = $clog2(MAG_W);

    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(MAG_W - 1);

    typedef struct packed {
        logic signed [OPERAND_WIDTH-1:0] first_num;
        logic signed [OPERAND_WIDTH-1:0] first_den;
        logic signed [OPERAND_WIDTH-1:0] second_num;
        logic signed [OPERAND_WIDTH-1:0] second_den;
    } item_t;

    typedef struct packed {
        logic signed [RES_W-1:0] reduced_num;
        logic signed [RES_W-1:0] reduced_den;
        logic                    zero_den_error;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] num_mag;
        logic [MAG_W-1:0] den_mag;
    } unit_req_t;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] num_quo;
        logic [MAG_W-1:0] den_quo;
    } unit_rsp_t;

endpackage

/* rtl/core/fmr_unit.sv */
// Iterative reduction unit: binary GCD, a rescale of the GCD by the common factors of two,
// then two restoring divisions. One subtractor serves the GCD and the divisions. Depends on fmr_pkg.
module fmr_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  fmr_pkg::unit_req_t  req,
    output fmr_pkg::unit_rsp_t  rsp
);

    typedef enum logic [5:0] {
        U_IDLE    = 6'b000001,
        U_REDUCE  = 6'b000010,
        U_SCALE   = 6'b000100,
        U_DIV_NUM = 6'b001000,
        U_DIV_DEN = 6'b010000,
        U_DONE    = 6'b100000
    } ustate_t;

    ustate_t                          state_reg, state_next;
    logic [fmr_pkg::MAG_W-1:0]        a_reg, a_next;
    logic [fmr_pkg::MAG_W-1:0]        b_reg, b_next;
    logic [fmr_pkg::MAG_W-1:0]        num_reg, num_next;
    logic [fmr_pkg::MAG_W-1:0]        den_reg, den_next;
    logic [fmr_pkg::MAG_W-1:0]        rem_reg, rem_next;
    logic [fmr_pkg::CNT_W-1:0]        k_reg, k_next;
    logic [fmr_pkg::CNT_W-1:0]        cnt_reg, cnt_next;

    logic                             div_msb;
    logic [fmr_pkg::MAG_W:0]          trial;
    logic [fmr_pkg::MAG_W:0]          sub_x, sub_y;
    logic [fmr_pkg::MAG_W+1:0]        diff;
    logic                             borrow;
    logic                             qbit;
    logic [fmr_pkg::MAG_W-1:0]        rem_step;

    assign div_msb = (state_reg == U_DIV_DEN) ? den_reg[fmr_pkg::MAG_W-1]
                                              : num_reg[fmr_pkg::MAG_W-1];
    assign trial   = {rem_reg, div_msb};

    always_comb
    begin
        if (state_reg == U_REDUCE)
        begin
            sub_x = {1'b0, a_reg};
            sub_y = {1'b0, b_reg};
        end
        else
        begin
            sub_x = trial;
            sub_y = {1'b0, a_reg};
        end
    end

    assign diff     = {1'b0, sub_x} - {1'b0, sub_y};
    assign borrow   = diff[fmr_pkg::MAG_W+1];
    assign qbit     = ~borrow;
    assign rem_step = borrow ? trial[fmr_pkg::MAG_W-1:0] : diff[fmr_pkg::MAG_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.num_mag;
                    b_next     = req.den_mag;
                    num_next   = req.num_mag;
                    den_next   = req.den_mag;
                    k_next     = '0;
                    state_next = U_REDUCE;
                end
            end
            U_REDUCE:
            begin
                if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + fmr_pkg::CNT_W'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (diff == '0)
                begin
                    state_next = U_SCALE;
                end
                else if (borrow)
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    a_next = diff[fmr_pkg::MAG_W-1:0] >> 1;
                end
            end
            U_SCALE:
            begin
                if (k_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = fmr_pkg::BIT_LAST;
                    state_next = U_DIV_NUM;
                end
                else
                begin
                    a_next = a_reg << 1;
                    k_next = k_reg - fmr_pkg::CNT_W'(1);
                end
            end
            U_DIV_NUM:
            begin
                num_next = {num_reg[fmr_pkg::MAG_W-2:0], qbit};
                rem_next = rem_step;
                cnt_next = cnt_reg - fmr_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = fmr_pkg::BIT_LAST;
                    state_next = U_DIV_DEN;
                end
            end
            U_DIV_DEN:
            begin
                den_next = {den_reg[fmr_pkg::MAG_W-2:0], qbit};
                rem_next = rem_step;
                cnt_next = cnt_reg - fmr_pkg::CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = U_DONE;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done    = (state_reg == U_DONE);
    assign rsp.num_quo = num_reg;
    assign rsp.den_quo = den_reg;

endmodule

/* rtl/core/fraction_multiply_reduce.sv */
// A transaction multiplies the numerators, then the denominators, then checks the products; when
// either product is zero the result is staged directly, otherwise fmr_unit runs the binary GCD
// (halving, swap, subtraction or final compare per step), rescales and divides both products.
// The next transaction is accepted only once the result is staged, which can wait on the result
// channel. fmr_unit makes one step per cycle with its single subtractor.
// Reset clears all control state; no result is pending after reset. Depends on fmr_pkg, fmr_unit.
module fraction_multiply_reduce (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  fmr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output fmr_pkg::result_t result
);

    typedef enum logic [5:0] {
        T_IDLE   = 6'b000001,
        T_MUL_N  = 6'b000010,
        T_MUL_D  = 6'b000100,
        T_CHECK  = 6'b001000,
        T_WAIT   = 6'b010000,
        T_FINISH = 6'b100000
    } tstate_t;

    tstate_t                          state_reg, state_next;
    fmr_pkg::item_t                   op_reg;
    logic signed [fmr_pkg::PROD_W-1:0] pn_reg, pd_reg;
    logic [fmr_pkg::RES_W-1:0]        res_num_reg, res_den_reg;
    logic                             res_err_reg;
    fmr_pkg::result_t                 result_reg;
    logic                             result_valid_reg, result_valid_next;

    logic signed [fmr_pkg::OPERAND_WIDTH-1:0] mul_x, mul_y;
    logic signed [fmr_pkg::PROD_W-1:0]        prod;
    logic                                     pn_neg, pd_neg;
    logic [fmr_pkg::PROD_W-1:0]               pn_abs, pd_abs;
    logic [fmr_pkg::WIDE_W-1:0]               qn_wide, qd_wide, sn_wide, sd_wide;
    logic                                     out_free;

    fmr_pkg::unit_req_t req;
    fmr_pkg::unit_rsp_t rsp;

    fmr_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign mul_x = (state_reg == T_MUL_D) ? op_reg.first_den  : op_reg.first_num;
    assign mul_y = (state_reg == T_MUL_D) ? op_reg.second_den : op_reg.second_num;
    assign prod  = mul_x * mul_y;

    assign pn_neg = pn_reg[fmr_pkg::PROD_W-1];
    assign pd_neg = pd_reg[fmr_pkg::PROD_W-1];
    assign pn_abs = pn_neg ? -pn_reg : pn_reg;
    assign pd_abs = pd_neg ? -pd_reg : pd_reg;

    assign req.start   = (state_reg == T_CHECK) && (pd_reg != '0) && (pn_reg != '0);
    assign req.num_mag = pn_abs[fmr_pkg::MAG_W-1:0];
    assign req.den_mag = pd_abs[fmr_pkg::MAG_W-1:0];

    assign qn_wide = fmr_pkg::WIDE_W'(rsp.num_quo);
    assign qd_wide = fmr_pkg::WIDE_W'(rsp.den_quo);
    assign sn_wide = pn_neg ? -qn_wide : qn_wide;
    assign sd_wide = pd_neg ? -qd_wide : qd_wide;

    assign out_free   = !result_valid_reg || result_ready;
    assign item_ready = (state_reg == T_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        case (state_reg)
            T_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = T_MUL_N;
                end
            end
            T_MUL_N:
            begin
                state_next = T_MUL_D;
            end
            T_MUL_D:
            begin
                state_next = T_CHECK;
            end
            T_CHECK:
            begin
                if (req.start)
                begin
                    state_next = T_WAIT;
                end
                else
                begin
                    state_next = T_FINISH;
                end
            end
            T_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = T_FINISH;
                end
            end
            T_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            op_reg <= item;
        end
        if (state_reg == T_MUL_N)
        begin
            pn_reg <= prod;
        end
        if (state_reg == T_MUL_D)
        begin
            pd_reg <= prod;
        end
        if (state_reg == T_CHECK)
        begin
            if (pd_reg == '0)
            begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                res_err_reg <= 1'b1;
            end
            else
            begin
                res_num_reg <= '0;
                res_den_reg <= fmr_pkg::RES_W'(1);
                res_err_reg <= 1'b0;
            end
        end
        if ((state_reg == T_WAIT) && rsp.done)
        begin
            res_num_reg <= sn_wide[fmr_pkg::RES_W-1:0];
            res_den_reg <= sd_wide[fmr_pkg::RES_W-1:0];
            res_err_reg <= 1'b0;
        end
        if ((state_reg == T_FINISH) && out_free)
        begin
            result_reg.reduced_num    <= res_num_reg;
            result_reg.reduced_den    <= res_den_reg;
            result_reg.zero_den_error <= res_err_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("Input ready stayed high after a transaction was accepted.");

    a_error_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_den_error) |->
            (result.reduced_num == '0 && result.reduced_den == '0))
        else $error("Zero denominator result carries nonzero fields.");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.zero_den_error) |-> (result.reduced_den != '0))
        else $error("Reduced denominator is zero without the error flag.");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == T_WAIT))
        else $error("Reduction unit finished while no transaction was waiting.");
`endif

endmodule

/* test/fraction_result_checker.sv */
`timescale 1ns / 1ps
// Checker for fraction_multiply_reduce: watches both channels, predicts each reduced
// product and compares it field by field. Depends on fmr_pkg.
module fraction_result_checker
    import fmr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_ready,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      fail_count,
    output int      outstanding
);

    result_t expected_fractions[$];

    function automatic longint unsigned common_divisor(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic result_t reduce_product(item_t it);
        longint          num_prod;
        longint          den_prod;
        longint unsigned num_mag;
        longint unsigned den_mag;
        longint unsigned g;
        result_t         r;
        num_prod = longint'($signed(it.first_num)) * longint'($signed(it.second_num));
        den_prod = longint'($signed(it.first_den)) * longint'($signed(it.second_den));
        num_mag  = (num_prod < 0) ? $unsigned(-num_prod) : $unsigned(num_prod);
        den_mag  = (den_prod < 0) ? $unsigned(-den_prod) : $unsigned(den_prod);
        r = '0;
        if (den_mag == 0)
        begin
            r.zero_den_error = 1'b1;
        end
        else if (num_mag == 0)
        begin
            r.reduced_den = 1;
        end
        else
        begin
            g = common_divisor(num_mag, den_mag);
            r.reduced_num = RES_W'((num_prod < 0) ? -(num_mag / g) : (num_mag / g));
            r.reduced_den = RES_W'((den_prod < 0) ? -(den_mag / g) : (den_mag / g));
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            expected_fractions.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_fractions.size() == 0)
                begin
                    $error("unexpected result transaction: reduced_num %0d, reduced_den %0d",
                           $signed(result.reduced_num), $signed(result.reduced_den));
                    fail_count++;
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (result.reduced_num !== want.reduced_num)
                    begin
                        $error("reduced_num: expected %0d, actual %0d",
                               $signed(want.reduced_num), $signed(result.reduced_num));
                        fail_count++;
                    end
                    if (result.reduced_den !== want.reduced_den)
                    begin
                        $error("reduced_den: expected %0d, actual %0d",
                               $signed(want.reduced_den), $signed(result.reduced_den));
                        fail_count++;
                    end
                    if (result.zero_den_error !== want.zero_den_error)
                    begin
                        $error("zero_den_error: expected %0b, actual %0b",
                               want.zero_den_error, result.zero_den_error);
                        fail_count++;
                    end
                end
            end
            if (item_valid && item_ready)
            begin
                expected_fractions.push_back(reduce_product(item));
            end
            outstanding = expected_fractions.size();
        end
    end

endmodule

/* test/tb_fraction_multiply_reduce.sv */
`timescale 1ns / 1ps
// Testbench top for fraction_multiply_reduce: drives fraction pairs and paces the result
// channel, then gives the verdict. Depends on fmr_pkg, fraction_multiply_reduce and fraction_result_checker.
module tb_fraction_multiply_reduce;
    import fmr_pkg::*;

    localparam int SIGNED_MAX  = 2 ** (OPERAND_WIDTH - 1) - 1;
    localparam int SIGNED_MIN  = -(2 ** (OPERAND_WIDTH - 1));
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 200;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      outstanding;
    int      send_idle;
    int      recv_stall;
    bit      hold_request;
    int      quiet_cycles;

    fraction_multiply_reduce u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    fraction_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL fraction_multiply_reduce");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [OPERAND_WIDTH-1:0] random_operand();
        int v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = 0;
                    1:       v = 1;
                    2:       v = -1;
                    3:       v = SIGNED_MAX;
                    default: v = SIGNED_MIN;
                endcase
            end
            1, 2:    v = $urandom_range(40);
            3:       v = $urandom_range(15) << $urandom_range(OPERAND_WIDTH - 5);
            default: v = $urandom_range(2 ** OPERAND_WIDTH - 1);
        endcase
        if ($urandom_range(1))
        begin
            v = -v;
        end
        return OPERAND_WIDTH'(v);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic drive_item(input item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_fractions(input int n1, input int d1, input int n2, input int d2);
        item_t it;
        it.first_num  = OPERAND_WIDTH'(n1);
        it.first_den  = OPERAND_WIDTH'(d1);
        it.second_num = OPERAND_WIDTH'(n2);
        it.second_den = OPERAND_WIDTH'(d2);
        drive_item(it);
    endtask

    task automatic send_random(input int count);
        repeat (count)
        begin
            drive_item(item_t'{random_operand(), random_operand(),
                               random_operand(), random_operand()});
        end
    endtask

    initial
    begin : receiver
        bit held;
        held         = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        send_idle    = 0;
        recv_stall   = 0;
        hold_request = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_fractions(0, 1, 5, 1);
        send_fractions(3, 0, 4, 5);
        send_fractions(0, 0, 0, 0);
        send_fractions(7, 0, 0, 9);
        send_fractions(2, 3, 0, 5);
        send_fractions(1, 1, 1, 1);
        send_fractions(SIGNED_MIN, 1, SIGNED_MIN, 1);
        send_fractions(SIGNED_MIN, SIGNED_MIN, SIGNED_MIN, SIGNED_MIN);
        send_fractions(SIGNED_MAX, SIGNED_MIN, SIGNED_MAX, SIGNED_MIN);
        send_fractions(SIGNED_MIN, SIGNED_MAX, SIGNED_MAX, SIGNED_MIN);
        send_fractions(SIGNED_MAX, 1, SIGNED_MAX, 1);
        send_fractions(1, SIGNED_MAX, 1, SIGNED_MAX);
        send_fractions(-1, 1, 1, 1);
        send_fractions(1, -1, 1, 1);
        send_fractions(-3, -4, 5, 7);
        send_fractions(6, 4, 1, 1);
        send_fractions(-6, -9, 1, 1);
        send_fractions(12345, 12345, 1, 1);
        send_fractions(16'h5555, 16'h2AAA, 16'h2AAA, 16'h5555);
        send_fractions(-1, -1, -1, -1);
        send_fractions(1, SIGNED_MIN, 1, 2);

        send_random(350);
        send_idle = 56;
        send_random(350);
        send_idle  = 0;
        recv_stall = 56;
        send_random(350);
        send_idle  = 34;
        recv_stall = 34;
        send_random(350);

        // The receiver holds off while items keep coming, so the block fills and stalls.
        send_idle    = 0;
        recv_stall   = 0;
        hold_request = 1'b1;
        send_random(100);
        item_valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
        begin
            $display("PASS fraction_multiply_reduce");
        end
        else
        begin
            if (outstanding != 0)
            begin
                $error("%0d expected results never arrived", outstanding);
            end
            $display("FAIL fraction_multiply_reduce");
        end
        $finish;
    end

endmodule
